// ===== rtl/icat_pkg.sv =====
// Package for the IR code action table: table geometry, opcodes, result kinds.
// No dependencies.
package icat_pkg;
  localparam int unsigned MacroCount  = 4;
  localparam int unsigned MacroLength = 8;
  localparam int unsigned WakeCount   = 8;
  localparam int unsigned SlotLen     = MacroLength + 1;
  localparam int unsigned WakeBase    = MacroCount * SlotLen;
  localparam int unsigned TableDepth  = WakeBase + WakeCount;
  localparam int unsigned AddrW       = $clog2(TableDepth);

  localparam logic [47:0] Empty48  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] AlarmOff = 32'hFFFF_FFFF;

  localparam logic [3:0] OpIr = 4'd0, OpRead = 4'd1, OpWrite = 4'd2, OpClear = 4'd3,
    OpAlRead = 4'd4, OpAlWrite = 4'd5, OpTick = 4'd6, OpSof = 4'd7, OpReboot = 4'd8,
    OpEmit = 4'd9;

  localparam logic [3:0] KOk = 4'd0, KFail = 4'd1, KEntry = 4'd2, KAlarm = 4'd3,
    KEmit = 4'd4, KWake = 4'd5, KReset = 4'd6, KReboot = 4'd7, KReport = 4'd8;

  localparam logic [15:0] TimeoutRst = 16'd500;
  localparam logic [10:0] TpsRst     = 11'd1000;
endpackage

// ===== rtl/icat_ram.sv =====
// Table storage: one write port, one registered read port, all-ones until written.
// Uses icat_pkg. Valid bits per entry give the empty reset value.
module icat_ram import icat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [47:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [47:0]      rdata_o
);
  logic [47:0] mem [TableDepth];
  logic [TableDepth-1:0] vld_q;
  logic [47:0] rd_q;
  logic rv_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rd_q <= mem[raddr_i];
  end

  // read-first: a write to the read address shows up on the next read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      rv_q <= vld_q[raddr_i];
      if (we_i) vld_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rv_q ? rd_q : Empty48;
endmodule

// ===== rtl/ir_code_action_table.sv =====
// IR code action table: macro and wake slots in one synchronous table memory.
// An IR code with flag bit 0 clear scans all TableDepth entries, one memory
// read per cycle while the output is not stalled; with flag bit 0 set it skips
// the scan and only reports the code.
// One input transfer at a time; the next is taken once the last result is queued.
// Reset (async, low): table reads empty, alarm off, counters zero, registers default.
module ir_code_action_table import icat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  opcode_i,
  input  logic        table_select_i,
  input  logic [3:0]  slot_i,
  input  logic [3:0]  position_i,
  input  logic [7:0]  code_protocol_i,
  input  logic [15:0] code_address_i,
  input  logic [15:0] code_command_i,
  input  logic [7:0]  code_flags_i,
  input  logic [31:0] alarm_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [7:0]  out_protocol_o,
  output logic [15:0] out_address_o,
  output logic [15:0] out_command_o,
  output logic [7:0]  out_flags_o,
  output logic [31:0] alarm_out_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SCAN, S_PUT, S_POST, S_WAKE, S_FIN, S_OUT
  } state_e;

  // result kinds queued behind the scan or behind the first result
  typedef enum logic [2:0] {
    P_NONE, P_REPORT, P_OK, P_REBOOT, P_ALARMWAKE
  } post_e;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(TableDepth - 1);
  localparam logic [AddrW-1:0] WakeAddr = AddrW'(WakeBase);

  state_e state_q;
  logic [3:0]  op_q;
  logic [47:0] code_q;
  logic [AddrW-1:0] ra_q;
  logic idx_ok_q;
  logic [31:0] alarm_q;
  logic [9:0]  ms_q;
  logic [15:0] sof_q, tmo_q;
  logic [10:0] tps_q;
  logic [3:0]  mpos_q;            // scan position within a macro slot
  logic        emit_q;            // current macro triggered and still emitting
  logic [2:0]  post_q;
  logic        wake_pend_q;

  // output register
  logic        ov_q, ol_q;
  logic [3:0]  ok_q;
  logic [47:0] oc_q;
  logic [31:0] oa_q;

  logic        we;
  logic [AddrW-1:0] wa, ra;
  logic [47:0] wd, rdat;

  icat_ram u_ram (
    .clk_i, .rst_ni, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rdat)
  );

  wire accept   = in_valid_i && !in_stall_o;
  wire out_free = !ov_q || !out_stall_i;
  wire idle_h   = sof_q >= tmo_q;
  // alarm wake due once this transfer's state updates are done
  wire wk_now   = (alarm_q == '0) && idle_h;

  // locate
  logic idx_ok;
  logic [AddrW-1:0] idx;
  always_comb begin
    if (table_select_i) begin
      idx_ok = 32'(slot_i) < WakeCount;
      idx    = AddrW'(WakeBase) + AddrW'(slot_i);
    end else begin
      idx_ok = (32'(slot_i) < MacroCount) && (32'(position_i) <= MacroLength);
      idx    = AddrW'(32'(slot_i) * SlotLen) + AddrW'(position_i);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, tmo_q} : {21'd0, tps_q};

  wire hit = (rdat != Empty48) && (rdat == code_q);
  wire [AddrW-1:0] sidx = ra_q - AddrW'(1);  // entry whose data is in rdat

  // scan read address; a stalled scan re-reads the entry it holds
  assign ra = (state_q == S_SCAN && !out_free) ? sidx : ra_q;

  // write port: clear/write in IDLE->direct, learn at wake slot 0 read
  always_comb begin
    we = 1'b0; wa = idx; wd = '0;
    if (accept && idx_ok) begin
      if (opcode_i == OpWrite) begin
        we = 1'b1;
        wd = {code_protocol_i, code_address_i, code_command_i, code_flags_i};
      end else if (opcode_i == OpClear) begin
        we = 1'b1; wd = Empty48;
      end
    end
    if (state_q == S_SCAN && sidx == WakeAddr && rdat == Empty48) begin
      we = 1'b1; wa = WakeAddr; wd = code_q;
    end
  end

  logic [47:0] pcode;
  always_comb pcode = {code_protocol_i, code_address_i, code_command_i, code_flags_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0; ol_q <= 1'b0; ok_q <= KOk; oc_q <= '0; oa_q <= '0;
      alarm_q <= AlarmOff; ms_q <= '0; sof_q <= '0;
      tmo_q <= TimeoutRst; tps_q <= TpsRst;
      op_q <= OpIr; code_q <= '0; idx_ok_q <= 1'b0; ra_q <= '0;
      mpos_q <= '0; emit_q <= 1'b0;
      post_q <= P_NONE; wake_pend_q <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr[2] == 1'b0) tmo_q <= pwdata[15:0];
        else tps_q <= pwdata[10:0];
      end
      case (state_q)
        S_IDLE: if (accept) begin
          op_q <= opcode_i; idx_ok_q <= idx_ok;
          code_q <= (opcode_i == OpIr) ? {pcode[47:8], 7'd0, pcode[0]} : pcode;
          ra_q <= (opcode_i == OpIr) ? '0 : idx;
          mpos_q <= '0; emit_q <= 1'b0;
          case (opcode_i)
            OpIr: begin
              state_q <= code_flags_i[0] ? S_POST : S_RD;
              post_q <= P_REPORT;
            end
            OpRead: state_q <= idx_ok ? S_RD : S_PUT;
            OpTick: begin
              if (sof_q < tmo_q) sof_q <= sof_q + 16'd1;
              if ({1'b0, ms_q} + 11'd1 >= tps_q) begin
                ms_q <= '0;
                if (alarm_q != '0 && alarm_q != AlarmOff) alarm_q <= alarm_q - 32'd1;
              end else ms_q <= ms_q + 10'd1;
              state_q <= S_WAKE;
            end
            OpSof: begin sof_q <= '0; state_q <= S_WAKE; end
            OpAlWrite: begin alarm_q <= alarm_in_i; state_q <= S_PUT; end
            default: state_q <= S_PUT;
          endcase
        end
        S_RD: begin
          // registered read; a scan moves on, an entry read holds its address
          if (op_q == OpIr) ra_q <= ra_q + AddrW'(1);
          state_q <= (op_q == OpIr) ? S_SCAN : S_PUT;
        end
        S_SCAN: if (out_free) begin
          // rdat holds entry sidx
          ra_q <= ra_q + AddrW'(1);
          if (32'(sidx) < WakeBase) begin
            if (mpos_q == '0) emit_q <= hit;
            else if (emit_q) begin
              if (rdat == Empty48) emit_q <= 1'b0;
              else begin
                ov_q <= 1'b1; ok_q <= KEmit; oc_q <= rdat; oa_q <= '0; ol_q <= 1'b0;
              end
            end
            if (32'(mpos_q) == MacroLength) mpos_q <= '0;
            else mpos_q <= mpos_q + 4'd1;
          end else begin
            if (sidx == WakeAddr && rdat == Empty48) begin
              // freshly learned code matches itself
              if (idle_h) begin
                alarm_q <= AlarmOff;
                ov_q <= 1'b1; ok_q <= KWake; oc_q <= '0; oa_q <= '0; ol_q <= 1'b0;
              end
            end else if (hit) begin
              if (32'(sidx) < WakeBase + WakeCount / 2) begin
                if (idle_h) begin
                  alarm_q <= AlarmOff;
                  ov_q <= 1'b1; ok_q <= KWake; oc_q <= '0; oa_q <= '0; ol_q <= 1'b0;
                end
              end else begin
                ov_q <= 1'b1; oc_q <= '0; oa_q <= '0; ol_q <= 1'b0;
                ok_q <= (sidx == LastAddr) ? KReboot : KReset;
              end
            end
          end
          if (sidx == LastAddr) state_q <= S_POST;
        end
        S_PUT: if (out_free) begin
          // last unless a second result or an alarm wake follows
          ov_q <= 1'b1; oc_q <= '0; oa_q <= '0; state_q <= S_WAKE;
          ol_q <= !wk_now && op_q != OpReboot && op_q != OpEmit;
          case (op_q)
            OpRead: if (idx_ok_q) begin ok_q <= KEntry; oc_q <= rdat; end
                    else ok_q <= KFail;
            OpWrite, OpClear: ok_q <= idx_ok_q ? KOk : KFail;
            OpAlRead: begin ok_q <= KAlarm; oa_q <= alarm_q; end
            OpAlWrite: ok_q <= KOk;
            OpReboot: begin ok_q <= KOk; post_q <= P_REBOOT; state_q <= S_POST; end
            OpEmit: begin ok_q <= KEmit; oc_q <= code_q; post_q <= P_OK; state_q <= S_POST; end
            default: ok_q <= KFail;
          endcase
        end
        S_POST: if (out_free) begin
          ov_q <= 1'b1; oc_q <= '0; oa_q <= '0; ol_q <= !wk_now; state_q <= S_WAKE;
          case (post_q)
            P_REPORT: begin ok_q <= KReport; oc_q <= code_q; end
            P_OK: ok_q <= KOk;
            default: ok_q <= KReboot;
          endcase
        end
        S_WAKE: begin
          // final alarm check
          wake_pend_q <= wk_now;
          if (wk_now) alarm_q <= AlarmOff;
          state_q <= S_FIN;
        end
        S_FIN: begin
          // alarm wake closes the transfer's results
          if (!wake_pend_q) state_q <= S_IDLE;
          else if (out_free) begin
            ov_q <= 1'b1; ok_q <= KWake; oc_q <= '0; oa_q <= '0; ol_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = ok_q;
  assign out_protocol_o = oc_q[47:40];
  assign out_address_o  = oc_q[39:24];
  assign out_command_o  = oc_q[23:8];
  assign out_flags_o    = oc_q[7:0];
  assign alarm_out_o    = oa_q;
  assign last_o         = ol_q;
endmodule

// ===== rtl/icat_checker.sv =====
// Port-level checker for the IR code action table, bound to the top level.
// Uses icat_pkg for kind codes.
module icat_checker import icat_pkg::*; (
  input logic clk_i, rst_ni, in_valid_i, in_stall_o, out_valid_o, out_stall_i,
  input logic [3:0] kind_o,
  input logic [31:0] alarm_out_o,
  input logic pready
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o))
    else $error("stalled result changed");
  a_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KAlarm |-> alarm_out_o == '0)
    else $error("alarm data on wrong kind");
endmodule

bind ir_code_action_table icat_checker u_chk (.*);
